[hw/rtl/three_way_byte_compare_unit_macros.svh]
// assertion macros used by the checker of the three-way byte compare unit
// no dependencies; take in with `include before any use
`ifndef THREE_WAY_BYTE_COMPARE_UNIT_MACROS_SVH
`define THREE_WAY_BYTE_COMPARE_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define TWBC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define TWBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/twbc_pkg.sv]
// types and constants of the three-way byte compare unit
// no dependencies; used by the top level and its checker

package twbc_pkg;

  localparam int BYTE_W = 8;
  localparam int CNT_W  = 21;
  localparam int POS_W  = 20;
  localparam int PCT_W  = 15;

  // product of consensus count and the Q7.8 percent scale
  localparam int NUM_W = CNT_W + PCT_W;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // 100 percent in Q7.8
  localparam logic [PCT_W-1:0] PCT_MAX = 15'd25600;

  // one quotient bit per divider step
  localparam int DIV_STEPS = PCT_W;
  localparam int STEP_W    = 4;

  typedef enum logic [1:0] {
    KIND_MATCH    = 2'd0,
    KIND_MISMATCH = 2'd1,
    KIND_INSERTED = 2'd2,
    KIND_DELETED  = 2'd3
  } kind_t;

endpackage

[hw/rtl/three_way_byte_compare_unit.sv]
// three-way byte compare: a non-last word goes straight into the output register on accept,
// or waits in ST_EMIT while that register is full; one word per cycle while the output side keeps up
// last word: in_ready drops through a setup step (ST_PREP), 15 steps of the restoring
// subtract/compare divider (ST_DIV) and the output load (ST_EMIT) before the statistics appear
// reset (rst, synchronous) clears the position and byte counters and empties the output;
// the counters also return to zero after every last word
// depends on twbc_pkg

module three_way_byte_compare_unit #(
  parameter logic [32:0] MAX_LENGTH = 33'd1048576
) (
  input  logic                                clk,
  input  logic                                rst,

  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [twbc_pkg::BYTE_W-1:0]         base_byte,
  input  logic                                has_base,
  input  logic [twbc_pkg::BYTE_W-1:0]         byte_a,
  input  logic                                has_a,
  input  logic [twbc_pkg::BYTE_W-1:0]         byte_b,
  input  logic                                has_b,
  input  logic                                last_position,

  // output channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [twbc_pkg::POS_W-1:0]          position,
  output twbc_pkg::kind_t                     kind,
  output logic                                final_item,
  output logic [twbc_pkg::CNT_W-1:0]          consensus_total,
  output logic [twbc_pkg::CNT_W-1:0]          conflict_total,
  output logic [twbc_pkg::PCT_W-1:0]          consensus_percent
);

  // counters stop at the smaller of the stream limit and their full range
  localparam logic [twbc_pkg::CNT_W-1:0] COUNT_CAP =
    (MAX_LENGTH < {12'd0, twbc_pkg::CNT_MAX}) ? MAX_LENGTH[twbc_pkg::CNT_W-1:0]
                                              : twbc_pkg::CNT_MAX;

  localparam logic [twbc_pkg::STEP_W-1:0] LAST_STEP =
    twbc_pkg::STEP_W'(twbc_pkg::DIV_STEPS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,   // ready for a word
    ST_EMIT,   // result held, waiting for the output register
    ST_PREP,   // form the dividend
    ST_DIV     // one quotient bit per cycle
  } state_t;

  state_t state;

  // running counters
  logic [twbc_pkg::CNT_W-1:0] offset_count;
  logic [twbc_pkg::CNT_W-1:0] consensus_count;
  logic [twbc_pkg::CNT_W-1:0] conflict_count;

  // held word
  logic [twbc_pkg::POS_W-1:0] wk_position;
  twbc_pkg::kind_t            wk_kind;
  logic                       wk_last;
  logic [twbc_pkg::CNT_W-1:0] wk_cons;
  logic [twbc_pkg::CNT_W-1:0] wk_conf;
  logic [twbc_pkg::CNT_W-1:0] wk_total;

  // divider registers
  logic [twbc_pkg::CNT_W-1:0]  div_rem;
  logic [twbc_pkg::PCT_W-1:0]  div_low;
  logic [twbc_pkg::PCT_W-1:0]  quot;
  logic [twbc_pkg::STEP_W-1:0] step;

  // classification of the incoming word
  twbc_pkg::kind_t cls_kind;
  logic            agree;
  logic            clash;
  logic            eq_ba;
  logic            eq_bb;
  logic            eq_ab;

  logic [twbc_pkg::CNT_W-1:0] offset_next;
  logic [twbc_pkg::CNT_W-1:0] consensus_next;
  logic [twbc_pkg::CNT_W-1:0] conflict_next;
  logic [twbc_pkg::POS_W-1:0] cur_position;

  logic                         accept;
  logic                         out_free;
  logic [twbc_pkg::NUM_W-1:0]   numer;
  logic [twbc_pkg::CNT_W:0]     trial;
  logic [twbc_pkg::CNT_W:0]     diff;
  logic                         qbit;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  // output register is empty or being emptied this cycle
  assign out_free = !out_valid || out_ready;

  assign eq_ba = (base_byte == byte_a);
  assign eq_bb = (base_byte == byte_b);
  assign eq_ab = (byte_a == byte_b);

  always_comb begin
    cls_kind = twbc_pkg::KIND_MATCH;
    agree    = 1'b0;
    clash    = 1'b0;
    if (has_base && has_a && has_b) begin
      if (eq_ba && eq_bb) begin
        agree = 1'b1;
      end else if (eq_ba || eq_bb) begin
        // only one branch moved away from base
        cls_kind = twbc_pkg::KIND_MISMATCH;
      end else if (eq_ab) begin
        // both branches made the same change
        agree = 1'b1;
      end else begin
        cls_kind = twbc_pkg::KIND_MISMATCH;
        clash    = 1'b1;
      end
    end else if (!has_base && has_a && has_b) begin
      if (eq_ab) begin
        cls_kind = twbc_pkg::KIND_INSERTED;
        agree    = 1'b1;
      end else begin
        cls_kind = twbc_pkg::KIND_MISMATCH;
        clash    = 1'b1;
      end
    end else if (has_a && !has_b) begin
      cls_kind = twbc_pkg::KIND_DELETED;
    end else if (!has_a && has_b) begin
      cls_kind = twbc_pkg::KIND_INSERTED;
    end
  end

  // saturating counter updates
  always_comb begin
    offset_next    = (offset_count < COUNT_CAP) ? offset_count + 1'b1 : COUNT_CAP;
    consensus_next = consensus_count;
    conflict_next  = conflict_count;
    if (agree) begin
      consensus_next = (consensus_count < COUNT_CAP) ? consensus_count + 1'b1 : COUNT_CAP;
    end
    if (clash) begin
      conflict_next = (conflict_count < COUNT_CAP) ? conflict_count + 1'b1 : COUNT_CAP;
    end
  end

  // position sticks at its top value on very long streams
  assign cur_position = offset_count[twbc_pkg::CNT_W-1] ? twbc_pkg::POS_MAX
                                                        : offset_count[twbc_pkg::POS_W-1:0];

  // consensus * 25600 = consensus * (16 + 8 + 1) << 10
  assign numer = ({15'd0, wk_cons} << 14) + ({15'd0, wk_cons} << 13)
               + ({15'd0, wk_cons} << 10);

  // restoring divider step; quotient never exceeds 15 bits since consensus <= total
  assign trial = {div_rem, div_low[twbc_pkg::PCT_W-1]};
  assign diff  = trial - {1'b0, wk_total};
  assign qbit  = (trial >= {1'b0, wk_total});

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      out_valid       <= 1'b0;
      offset_count    <= '0;
      consensus_count <= '0;
      conflict_count  <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            wk_position <= cur_position;
            wk_kind     <= cls_kind;
            wk_last     <= last_position;
            if (last_position) begin
              // totals go to the divider, counters start over
              wk_cons         <= consensus_next;
              wk_conf         <= conflict_next;
              wk_total        <= offset_next;
              offset_count    <= '0;
              consensus_count <= '0;
              conflict_count  <= '0;
              state           <= ST_PREP;
            end else begin
              offset_count    <= offset_next;
              consensus_count <= consensus_next;
              conflict_count  <= conflict_next;
              if (out_free) begin
                // straight into the output register
                out_valid         <= 1'b1;
                position          <= cur_position;
                kind              <= cls_kind;
                final_item        <= 1'b0;
                consensus_total   <= '0;
                conflict_total    <= '0;
                consensus_percent <= '0;
              end else begin
                state <= ST_EMIT;
              end
            end
          end
        end
        ST_PREP: begin
          div_rem <= numer[twbc_pkg::NUM_W-1:twbc_pkg::PCT_W];
          div_low <= numer[twbc_pkg::PCT_W-1:0];
          quot    <= '0;
          step    <= '0;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          div_rem <= qbit ? diff[twbc_pkg::CNT_W-1:0] : trial[twbc_pkg::CNT_W-1:0];
          div_low <= {div_low[twbc_pkg::PCT_W-2:0], 1'b0};
          quot    <= {quot[twbc_pkg::PCT_W-2:0], qbit};
          step    <= step + 1'b1;
          if (step == LAST_STEP) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid         <= 1'b1;
            position          <= wk_position;
            kind              <= wk_kind;
            final_item        <= wk_last;
            consensus_total   <= wk_last ? wk_cons : '0;
            conflict_total    <= wk_last ? wk_conf : '0;
            consensus_percent <= wk_last ? quot : '0;
            state             <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/twbc_checker.sv]
// port-level checker for the three-way byte compare unit, bound to the top level
// depends on twbc_pkg and three_way_byte_compare_unit_macros.svh
`include "three_way_byte_compare_unit_macros.svh"

module twbc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [twbc_pkg::POS_W-1:0]   position,
  input logic [1:0]                   kind,
  input logic                         final_item,
  input logic [twbc_pkg::CNT_W-1:0]   consensus_total,
  input logic [twbc_pkg::CNT_W-1:0]   conflict_total,
  input logic [twbc_pkg::PCT_W-1:0]   consensus_percent
);

  // statistics are zero on ordinary words
  `TWBC_ASSERT_NOW(a_stats_zero, clk, rst, out_valid && !final_item, consensus_total == '0 && conflict_total == '0 && consensus_percent == '0, "statistics set on a non-final word")

  // rate never passes 100 percent
  `TWBC_ASSERT_NOW(a_pct_range, clk, rst, out_valid && final_item, consensus_percent <= twbc_pkg::PCT_MAX, "consensus percent above 100")

  // stalled statistics hold
  `TWBC_ASSERT_NEXT(a_stats_hold, clk, rst, out_valid && !out_ready, $stable(consensus_total) && $stable(conflict_total) && $stable(consensus_percent), "statistics changed while stalled")

  // stalled result holds
  `TWBC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(position) && $stable(kind) && $stable(final_item), "output word changed while stalled")

endmodule

bind three_way_byte_compare_unit twbc_checker u_twbc_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .position          (position),
  .kind              (kind),
  .final_item        (final_item),
  .consensus_total   (consensus_total),
  .conflict_total    (conflict_total),
  .consensus_percent (consensus_percent)
);
